// ===== rtl/sks_pkg.sv =====
package sks_pkg;

  // Default configuration
  localparam int MaxRecords = 64;
  localparam int KeyBits    = 16;
  localparam int TagBits    = 16;

  // Fixed port field width
  localparam int FieldBits  = 16;

  typedef struct packed {
    logic [FieldBits-1:0] key;
    logic [FieldBits-1:0] tag;
    logic                 final_item;
  } in_word_t;

  typedef struct packed {
    logic [FieldBits-1:0] sorted_key;
    logic [FieldBits-1:0] sorted_tag;
    logic                 run_end;
    logic                 dropped;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_LOADC,
    ST_STEP,
    ST_PASS_END,
    ST_OUT_RD,
    ST_OUT_SHOW
  } state_e;

  // Source of the store write data
  typedef enum logic [1:0] {
    WR_INPUT,
    WR_STEP,
    WR_CARRY
  } wsel_e;

  // Update of the carried record
  typedef enum logic [1:0] {
    CARRY_HOLD,
    CARRY_LOAD,
    CARRY_STEP
  } carry_op_e;

  typedef struct packed {
    logic      we;
    wsel_e     wsel;
    logic      re;
    carry_op_e carry_op;
  } dp_cmd_t;

endpackage

// ===== rtl/sks_datapath.sv =====
module sks_datapath #(
  parameter int MAX_RECORDS = sks_pkg::MaxRecords,
  parameter int KEY_BITS    = sks_pkg::KeyBits,
  parameter int TAG_BITS    = sks_pkg::TagBits
) (
  input  logic                           clk_i,
  input  sks_pkg::dp_cmd_t               cmd_i,
  input  logic [$clog2(MAX_RECORDS)-1:0] waddr_i,
  input  logic [$clog2(MAX_RECORDS)-1:0] raddr_i,
  input  sks_pkg::in_word_t              in_word_i,
  output logic [sks_pkg::FieldBits-1:0]  rd_key_o,
  output logic [sks_pkg::FieldBits-1:0]  rd_tag_o
);

  logic [KEY_BITS-1:0] key_mem [MAX_RECORDS];
  logic [TAG_BITS-1:0] tag_mem [MAX_RECORDS];

  logic [KEY_BITS-1:0] rkey_q;
  logic [TAG_BITS-1:0] rtag_q;
  logic [KEY_BITS-1:0] ckey_q, ckey_d;
  logic [TAG_BITS-1:0] ctag_q, ctag_d;
  logic [KEY_BITS-1:0] wkey;
  logic [TAG_BITS-1:0] wtag;
  logic                swap;

  // Earlier record strictly greater: it moves up, carried record stays
  assign swap = rkey_q > ckey_q;

  // Select write data
  always_comb begin
    case (cmd_i.wsel)
      sks_pkg::WR_INPUT: begin
        wkey = KEY_BITS'(in_word_i.key);
        wtag = TAG_BITS'(in_word_i.tag);
      end
      sks_pkg::WR_STEP: begin
        wkey = swap ? rkey_q : ckey_q;
        wtag = swap ? rtag_q : ctag_q;
      end
      sks_pkg::WR_CARRY: begin
        wkey = ckey_q;
        wtag = ctag_q;
      end
      default: begin
        wkey = ckey_q;
        wtag = ctag_q;
      end
    endcase
  end

  // Update the carried record
  always_comb begin
    case (cmd_i.carry_op)
      sks_pkg::CARRY_LOAD: begin
        ckey_d = rkey_q;
        ctag_d = rtag_q;
      end
      sks_pkg::CARRY_STEP: begin
        ckey_d = swap ? ckey_q : rkey_q;
        ctag_d = swap ? ctag_q : rtag_q;
      end
      default: begin
        ckey_d = ckey_q;
        ctag_d = ctag_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ckey_q <= ckey_d;
    ctag_q <= ctag_d;
  end

  // Record store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      key_mem[waddr_i] <= wkey;
      tag_mem[waddr_i] <= wtag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.re) begin
      rkey_q <= key_mem[raddr_i];
      rtag_q <= tag_mem[raddr_i];
    end
  end

  assign rd_key_o = sks_pkg::FieldBits'(rkey_q);
  assign rd_tag_o = sks_pkg::FieldBits'(rtag_q);

endmodule

// ===== rtl/sks_ctrl.sv =====
module sks_ctrl #(
  parameter int MAX_RECORDS = sks_pkg::MaxRecords
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_final_i,
  output logic                           in_stall_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           run_end_o,
  output logic                           dropped_o,
  output sks_pkg::dp_cmd_t               cmd_o,
  output logic [$clog2(MAX_RECORDS)-1:0] waddr_o,
  output logic [$clog2(MAX_RECORDS)-1:0] raddr_o
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  sks_pkg::state_e state_q, state_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic            ovf_q, ovf_d;
  logic [AW-1:0]   pass_q, pass_d;
  logic [AW-1:0]   pos_q, pos_d;

  logic          in_acc;
  logic          out_acc;
  logic          has_room;
  logic [CW-1:0] run_len;
  logic [AW-1:0] top_idx;
  logic          last_out;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign has_room = fill_q < CW'(MAX_RECORDS);
  assign run_len  = has_room ? fill_q + CW'(1) : fill_q;
  assign top_idx  = AW'(fill_q - CW'(1));
  assign last_out = (CW'(pos_q) + CW'(1)) == fill_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sks_pkg::ST_IDLE: begin
        if (in_acc && in_final_i) begin
          state_d = (run_len >= CW'(2)) ? sks_pkg::ST_PRIME : sks_pkg::ST_OUT_RD;
        end
      end
      sks_pkg::ST_PRIME:    state_d = sks_pkg::ST_LOADC;
      sks_pkg::ST_LOADC:    state_d = sks_pkg::ST_STEP;
      sks_pkg::ST_STEP: begin
        if (pos_q - AW'(1) == pass_q) begin
          state_d = sks_pkg::ST_PASS_END;
        end
      end
      sks_pkg::ST_PASS_END: begin
        state_d = (CW'(pass_q) + CW'(2) == fill_q) ? sks_pkg::ST_OUT_RD
                                                   : sks_pkg::ST_PRIME;
      end
      sks_pkg::ST_OUT_RD:   state_d = sks_pkg::ST_OUT_SHOW;
      sks_pkg::ST_OUT_SHOW: begin
        if (out_acc) begin
          state_d = last_out ? sks_pkg::ST_IDLE : sks_pkg::ST_OUT_RD;
        end
      end
      default:              state_d = sks_pkg::ST_IDLE;
    endcase
  end

  // Commands and counter updates
  always_comb begin
    cmd_o       = '{we: 1'b0, wsel: sks_pkg::WR_INPUT, re: 1'b0,
                    carry_op: sks_pkg::CARRY_HOLD};
    waddr_o     = pos_q;
    raddr_o     = pos_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    run_end_o   = last_out;
    dropped_o   = ovf_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    pass_d      = pass_q;
    pos_d       = pos_q;
    case (state_q)
      sks_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        waddr_o    = AW'(fill_q);
        pass_d     = '0;
        pos_d      = '0;
        if (in_acc) begin
          // Store the word, or drop it when full
          if (has_room) begin
            cmd_o.we = 1'b1;
            fill_d   = fill_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      sks_pkg::ST_PRIME: begin
        // Fetch the top record of the run as the carried record
        cmd_o.re = 1'b1;
        raddr_o  = top_idx;
        pos_d    = top_idx;
      end
      sks_pkg::ST_LOADC: begin
        cmd_o.carry_op = sks_pkg::CARRY_LOAD;
        cmd_o.re       = 1'b1;
        raddr_o        = pos_q - AW'(1);
      end
      sks_pkg::ST_STEP: begin
        // Compare neighbor with carried record, write back the larger
        cmd_o.carry_op = sks_pkg::CARRY_STEP;
        cmd_o.we       = 1'b1;
        cmd_o.wsel     = sks_pkg::WR_STEP;
        waddr_o        = pos_q;
        if (pos_q - AW'(1) != pass_q) begin
          cmd_o.re = 1'b1;
          raddr_o  = pos_q - AW'(2);
          pos_d    = pos_q - AW'(1);
        end
      end
      sks_pkg::ST_PASS_END: begin
        // Settle the pass minimum at its final place
        cmd_o.we   = 1'b1;
        cmd_o.wsel = sks_pkg::WR_CARRY;
        waddr_o    = pass_q;
        pass_d     = pass_q + AW'(1);
        pos_d      = '0;
      end
      sks_pkg::ST_OUT_RD: begin
        cmd_o.re = 1'b1;
        raddr_o  = pos_q;
      end
      sks_pkg::ST_OUT_SHOW: begin
        out_valid_o = 1'b1;
        if (out_acc) begin
          if (last_out) begin
            fill_d = '0;
            ovf_d  = 1'b0;
          end else begin
            pos_d = pos_q + AW'(1);
          end
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sks_pkg::ST_IDLE;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      pass_q  <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      pass_q  <= pass_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// ===== rtl/stable_key_tag_sorter.sv =====
// Stable ascending sorter for key/tag records.
// Input channel: in_valid_i / in_stall_o carry one record word (key, tag,
// final_item). Records are stored one per cycle; records beyond
// MAX_RECORDS are dropped. A word with final_item set closes the set.
// The set is then bubble sorted in place in a single-port-write record
// store, one compare-and-write per cycle with the moving record held in a
// register. Equal keys keep arrival order. Output channel: out_valid_o /
// out_stall_i return the run in order, each word read from the store and
// then shown, the next one read only after it is taken; run_end marks the
// last word and dropped every word of a run that lost records. A stalled
// word holds. in_stall_o stays high from the final word until the last
// result is taken. Reset clears the counters and returns to collecting;
// the store needs no clearing, entries are read only after they are written.
module stable_key_tag_sorter #(
  parameter int MAX_RECORDS = sks_pkg::MaxRecords,
  parameter int KEY_BITS    = sks_pkg::KeyBits,
  parameter int TAG_BITS    = sks_pkg::TagBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  sks_pkg::in_word_t  in_word_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output sks_pkg::out_word_t out_word_o,
  input  logic               out_stall_i
);

  localparam int AW = $clog2(MAX_RECORDS);

  sks_pkg::dp_cmd_t              cmd;
  logic [AW-1:0]                 waddr;
  logic [AW-1:0]                 raddr;
  logic [sks_pkg::FieldBits-1:0] rd_key;
  logic [sks_pkg::FieldBits-1:0] rd_tag;
  logic                          run_end;
  logic                          dropped;

  sks_ctrl #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_final_i (in_word_i.final_item),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .run_end_o  (run_end),
    .dropped_o  (dropped),
    .cmd_o      (cmd),
    .waddr_o    (waddr),
    .raddr_o    (raddr)
  );

  sks_datapath #(
    .MAX_RECORDS(MAX_RECORDS),
    .KEY_BITS   (KEY_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .waddr_i  (waddr),
    .raddr_i  (raddr),
    .in_word_i(in_word_i),
    .rd_key_o (rd_key),
    .rd_tag_o (rd_tag)
  );

  // Assemble the result word
  assign out_word_o = '{sorted_key: rd_key, sorted_tag: rd_tag,
                        run_end: run_end, dropped: dropped};

  // Input and output phases never overlap
  a_phase_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o))
    else $error("input taken while results pending");

  // A final word closes the input side
  a_final_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_word_i.final_item) |=> in_stall_o)
    else $error("input not stalled after final word");

  // The run ends after its last word is taken
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_word_o.run_end) |=>
      (!out_valid_o && !in_stall_o))
    else $error("run did not end after last word");

  // No store write while results are shown
  a_no_write_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !cmd.we)
    else $error("store written during output");

endmodule
